/* rtl/core/tomq_pkg.sv */
// Shared types and codes for the timestamp ordered multi-queue merge.
// Depends on nothing; the merge top and tomq_qstate in rtl/core refer to it by scope.
package tomq_pkg;

  // Function codes of an input transaction.
  localparam logic FN_ENQ = 1'b0;
  localparam logic FN_DEQ = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_DISABLED = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  // Fixed field widths.
  localparam int unsigned ENABLE_W = 8;
  localparam int unsigned LIMIT_W  = 5;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CLIENT_W = 3;
  localparam int unsigned NOTE_W   = 32;
  localparam int unsigned STAMP_W  = 64;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

  // Update command for the per-client queue state.
  typedef struct packed {
    logic push;
    logic pop;
  } qs_cmd_t;

endpackage

/* rtl/core/timestamp_ordered_multi_queue_merge.sv */
// Channel    | Ports                                           | Direction
// input      | in_valid in_stall in_func in_client_index        | in (stall out)
//            | in_note_data in_timestamp                        |
// result     | out_valid out_stall out_status out_client        | out (stall in)
//            | out_note out_timestamp                           |
// config     | cfg_we cfg_index cfg_wdata                       | in
//
// An enqueue is checked and committed in state S_ENQ. A dequeue runs S_SCAN, S_DRAIN
// and S_POP: the min(NUM_CLIENTS,8) client heads are read one per cycle through
// the single read port of the note store and compared against the running oldest.
// One transaction is in work at a time; a new one is accepted while a result waits.
// Reset clears head pointers, fill counts and registers at once; no clearing pass.
// A stalled result holds the commit of the transaction behind it until it is taken.
// Depends on tomq_pkg, tomq_store and tomq_qstate.
module timestamp_ordered_multi_queue_merge #(
  parameter int unsigned NUM_CLIENTS = 8,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NOTE_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [tomq_pkg::CLIENT_W-1:0]       in_client_index,
  input  logic [tomq_pkg::NOTE_W-1:0]         in_note_data,
  input  logic [tomq_pkg::STAMP_W-1:0]        in_timestamp,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [tomq_pkg::CLIENT_W-1:0]       out_client,
  output logic [tomq_pkg::NOTE_W-1:0]         out_note,
  output logic [tomq_pkg::STAMP_W-1:0]        out_timestamp,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [tomq_pkg::CFG_W-1:0]          cfg_wdata
);

  // Only clients that the enable register can reach get storage.
  localparam int unsigned NCL   = (NUM_CLIENTS < 8) ? NUM_CLIENTS : 8;
  localparam int unsigned CW    = (NCL > 1) ? $clog2(NCL) : 1;
  localparam int unsigned PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DEPTH = NCL * QUEUE_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = (NOTE_WIDTH < 32) ? NOTE_WIDTH : 32;
  localparam int unsigned WW    = SW + tomq_pkg::STAMP_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENQ   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [tomq_pkg::ENABLE_W-1:0] enable_r;
  logic [tomq_pkg::LIMIT_W-1:0]  limit_r;

  // Latched transaction.
  logic [tomq_pkg::CLIENT_W-1:0]   cli_r;
  logic [SW-1:0]                   note_r;
  logic [tomq_pkg::STAMP_W-1:0]    stamp_r;

  // Scan state.
  logic [CW-1:0]                   cnt_r;
  logic                            pv_r;
  logic [CW-1:0]                   pc_r;
  logic                            found_r;
  logic [CW-1:0]                   best_r;
  logic [tomq_pkg::STAMP_W-1:0]    best_stamp_r;
  logic [SW-1:0]                   best_note_r;

  // Result register.
  logic                            out_valid_r;
  logic [1:0]                      out_status_r;
  logic [tomq_pkg::CLIENT_W-1:0]   out_client_r;
  logic [tomq_pkg::NOTE_W-1:0]     out_note_r;
  logic [tomq_pkg::STAMP_W-1:0]    out_stamp_r;

  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic [1:0]        load_status;
  logic [NCL-1:0]    en_vec;
  logic [CW-1:0]     qs_idx;
  tomq_pkg::qs_cmd_t qs_cmd;
  logic [PW-1:0]     qs_head;
  logic [FW-1:0]     qs_fill;
  logic              cli_ok;
  logic              is_full;
  logic [PW:0]       pos_sum;
  logic [PW-1:0]     pos;
  logic              mem_we, mem_re;
  logic [AW-1:0]     waddr, raddr;
  logic [WW-1:0]     rdata;
  logic [tomq_pkg::STAMP_W-1:0] rd_stamp;
  logic [SW-1:0]     rd_note;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign en_vec   = enable_r[NCL-1:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
      limit_r  <= tomq_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tomq_pkg::CFG_ENABLE: enable_r <= cfg_wdata[tomq_pkg::ENABLE_W-1:0];
        tomq_pkg::CFG_LIMIT:  limit_r  <= cfg_wdata[tomq_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cli_r   <= in_client_index;
      note_r  <= in_note_data[SW-1:0];
      stamp_r <= in_timestamp;
    end
  end

  // Queue state is addressed by the enqueue client, the scan counter or the winner.
  always_comb begin
    if (state_r == S_ENQ) begin
      qs_idx = cli_r[CW-1:0];
    end else if (state_r == S_SCAN) begin
      qs_idx = cnt_r;
    end else begin
      qs_idx = best_r;
    end
  end

  assign cli_ok  = ({1'b0, cli_r} < 4'(NCL)) && en_vec[cli_r[CW-1:0]];
  assign is_full = (9'(qs_fill) >= 9'(limit_r)) || (9'(qs_fill) >= 9'(QUEUE_DEPTH));
  assign pos_sum = (PW+1)'(qs_head) + (PW+1)'(qs_fill);
  assign pos     = (pos_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                   PW'(pos_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(pos_sum);

  assign waddr = AW'(qs_idx) * AW'(QUEUE_DEPTH) + AW'(pos);
  assign raddr = AW'(qs_idx) * AW'(QUEUE_DEPTH) + AW'(qs_head);

  assign mem_we = (state_r == S_ENQ) && out_free && cli_ok && !is_full;
  assign mem_re = (state_r == S_SCAN) && en_vec[cnt_r] && (qs_fill != '0);

  always_comb begin
    qs_cmd.push = mem_we;
    qs_cmd.pop  = (state_r == S_POP) && out_free && found_r;
  end

  tomq_qstate #(
    .NCL(NCL), .QUEUE_DEPTH(QUEUE_DEPTH), .CW(CW), .PW(PW), .FW(FW)
  ) u_qstate (
    .clk(clk), .rst_n(rst_n), .idx(qs_idx), .cmd(qs_cmd),
    .head(qs_head), .fill(qs_fill)
  );

  tomq_store #(
    .DEPTH(DEPTH), .WIDTH(WW), .AW(AW)
  ) u_store (
    .clk(clk), .we(mem_we), .waddr(waddr), .wdata({note_r, stamp_r}),
    .re(mem_re), .raddr(raddr), .rdata(rdata)
  );

  assign rd_stamp = rdata[tomq_pkg::STAMP_W-1:0];
  assign rd_note  = rdata[WW-1:tomq_pkg::STAMP_W];

  // Scan: issue one head read per cycle, compare it in the cycle after, from the registered read data.
  // The <= keeps the highest-numbered client on equal timestamps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      found_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      pv_r <= mem_re;
      pc_r <= cnt_r;
      if (in_acc) begin
        found_r <= 1'b0;
        cnt_r   <= '0;
      end else begin
        if (state_r == S_SCAN) begin
          cnt_r <= cnt_r + CW'(1);
        end
        if (pv_r && (!found_r || rd_stamp <= best_stamp_r)) begin
          found_r      <= 1'b1;
          best_r       <= pc_r;
          best_stamp_r <= rd_stamp;
          best_note_r  <= rd_note;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_func == tomq_pkg::FN_ENQ) ? S_ENQ : S_SCAN;
        end
      end
      S_ENQ: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (cnt_r == CW'(NCL - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_POP;
      S_POP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_load = ((state_r == S_ENQ) || (state_r == S_POP)) && out_free;

  always_comb begin
    if (state_r == S_ENQ) begin
      if (!cli_ok) begin
        load_status = tomq_pkg::ST_DISABLED;
      end else if (is_full) begin
        load_status = tomq_pkg::ST_FULL;
      end else begin
        load_status = tomq_pkg::ST_OK;
      end
    end else begin
      load_status = found_r ? tomq_pkg::ST_OK : tomq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= load_status;
      if ((state_r == S_POP) && found_r) begin
        out_client_r <= tomq_pkg::CLIENT_W'(best_r);
        out_note_r   <= tomq_pkg::NOTE_W'(best_note_r);
        out_stamp_r  <= best_stamp_r;
      end else begin
        out_client_r <= '0;
        out_note_r   <= '0;
        out_stamp_r  <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_client    = out_client_r;
  assign out_note      = out_note_r;
  assign out_timestamp = out_stamp_r;

  // A pop only ever hits a queue that holds a note.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    qs_cmd.pop |-> (qs_fill != '0))
    else $error("pop from an empty client queue");

  // A push never overruns the physical queue depth.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    qs_cmd.push |-> (32'(qs_fill) < QUEUE_DEPTH))
    else $error("push into a full client queue");

  // A pending head read only exists while the scan is running or draining.
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> ((state_r == S_SCAN) || (state_r == S_DRAIN)))
    else $error("head read outside of a dequeue scan");

  // A result waiting under stall is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("result register overwritten while stalled");

endmodule

/* rtl/core/tomq_store.sv */
// Note and timestamp store: one write port, one read port, registered read data.
// Depends on nothing outside this file.
module tomq_store #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 96,
  parameter int unsigned AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/tomq_qstate.sv */
// Per-client head pointer and fill count, read at one index and updated there.
// Depends on tomq_pkg for the update command type.
module tomq_qstate #(
  parameter int unsigned NCL         = 8,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned CW          = 3,
  parameter int unsigned PW          = 4,
  parameter int unsigned FW          = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CW-1:0]     idx,
  input  tomq_pkg::qs_cmd_t cmd,
  output logic [PW-1:0]     head,
  output logic [FW-1:0]     fill
);

  logic [PW-1:0] head_r [NCL];
  logic [FW-1:0] fill_r [NCL];

  assign head = head_r[idx];
  assign fill = fill_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCL; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (cmd.push) begin
      fill_r[idx] <= fill_r[idx] + FW'(1);
    end else if (cmd.pop) begin
      head_r[idx] <= (head_r[idx] == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r[idx] + PW'(1);
      fill_r[idx] <= fill_r[idx] - FW'(1);
    end
  end

endmodule

/* dv/tomq_merge_checker.sv */
// Checker for the timestamp ordered multi-queue merge: predicts every result and compares it.
// It watches the input, result and register write ports of the block.
// Depends on tomq_pkg for widths and codes.
module tomq_merge_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_func,
  input  logic [tomq_pkg::CLIENT_W-1:0] in_client_index,
  input  logic [tomq_pkg::NOTE_W-1:0]   in_note_data,
  input  logic [tomq_pkg::STAMP_W-1:0]  in_timestamp,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [1:0]                    out_status,
  input  logic [tomq_pkg::CLIENT_W-1:0] out_client,
  input  logic [tomq_pkg::NOTE_W-1:0]   out_note,
  input  logic [tomq_pkg::STAMP_W-1:0]  out_timestamp,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [tomq_pkg::CFG_W-1:0]    cfg_wdata,
  output int unsigned                   error_count,
  output int unsigned                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLIENTS = 8;
  localparam int unsigned DEPTH   = 16;

  typedef struct packed {
    logic [1:0]                    status;
    logic [tomq_pkg::CLIENT_W-1:0] client;
    logic [tomq_pkg::NOTE_W-1:0]   note;
    logic [tomq_pkg::STAMP_W-1:0]  stamp;
  } merge_result_t;

  logic [tomq_pkg::NOTE_W-1:0]   note_mem  [CLIENTS][DEPTH];
  logic [tomq_pkg::STAMP_W-1:0]  stamp_mem [CLIENTS][DEPTH];
  logic [3:0]                    head_ptr  [CLIENTS];
  logic [4:0]                    fill_cnt  [CLIENTS];
  logic [tomq_pkg::ENABLE_W-1:0] enable_mask;
  logic [tomq_pkg::LIMIT_W-1:0]  limit_reg;
  merge_result_t                 awaited_results [$];
  int unsigned                   errs = 0;

  // Applies one transaction to the queue copy and returns the result it causes.
  function automatic merge_result_t oldest_first_step(logic fn,
                                                      logic [tomq_pkg::CLIENT_W-1:0] client,
                                                      logic [tomq_pkg::NOTE_W-1:0] note,
                                                      logic [tomq_pkg::STAMP_W-1:0] stamp);
    merge_result_t                r;
    int unsigned                  cap;
    logic [3:0]                   slot;
    bit                           found;
    int unsigned                  best;
    logic [tomq_pkg::STAMP_W-1:0] best_stamp;
    r = '0;
    found = 1'b0;
    best = 0;
    best_stamp = '0;
    // Limits above the physical depth behave as the full depth.
    cap = (32'(limit_reg) > DEPTH) ? DEPTH : 32'(limit_reg);
    if (fn == tomq_pkg::FN_ENQ) begin
      if (!enable_mask[client]) begin
        r.status = tomq_pkg::ST_DISABLED;
      end else if (32'(fill_cnt[client]) >= cap) begin
        r.status = tomq_pkg::ST_FULL;
      end else begin
        slot = head_ptr[client] + fill_cnt[client][3:0];
        note_mem[client][slot] = note;
        stamp_mem[client][slot] = stamp;
        fill_cnt[client]++;
        r.status = tomq_pkg::ST_OK;
      end
    end else begin
      // Ascending scan with <= lets the highest client win a tie.
      for (int c = 0; c < CLIENTS; c++) begin
        if (enable_mask[c] && fill_cnt[c] != 0 &&
            (!found || stamp_mem[c][head_ptr[c]] <= best_stamp)) begin
          found = 1'b1;
          best = c;
          best_stamp = stamp_mem[c][head_ptr[c]];
        end
      end
      if (!found) begin
        r.status = tomq_pkg::ST_EMPTY;
      end else begin
        r.status = tomq_pkg::ST_OK;
        r.client = tomq_pkg::CLIENT_W'(best);
        r.note = note_mem[best][head_ptr[best]];
        r.stamp = best_stamp;
        head_ptr[best]++;
        fill_cnt[best]--;
      end
    end
    return r;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    merge_result_t want_r;
    if (!rst_n) begin
      for (int c = 0; c < CLIENTS; c++) begin
        head_ptr[c] = '0;
        fill_cnt[c] = '0;
      end
      enable_mask = '0;
      limit_reg = tomq_pkg::LIMIT_RST;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == tomq_pkg::CFG_ENABLE) begin
          enable_mask = cfg_wdata[tomq_pkg::ENABLE_W-1:0];
        end else begin
          limit_reg = cfg_wdata[tomq_pkg::LIMIT_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        awaited_results.push_back(oldest_first_step(in_func, in_client_index,
                                                    in_note_data, in_timestamp));
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no expectation pending: status %0d", out_status);
          errs++;
        end else begin
          want_r = awaited_results.pop_front();
          check_field("status", 64'(want_r.status), 64'(out_status));
          check_field("client", 64'(want_r.client), 64'(out_client));
          check_field("note", 64'(want_r.note), 64'(out_note));
          check_field("timestamp", want_r.stamp, out_timestamp);
        end
      end
    end
    outstanding <= awaited_results.size();
    error_count <= errs;
  end

endmodule

/* dv/timestamp_ordered_multi_queue_merge_test.sv */
// Top of the testbench for the timestamp ordered multi-queue merge: clock, reset,
// directed and random transactions, receiver back-pressure and the verdict.
// Depends on tomq_pkg, the block itself and tomq_merge_checker.
module timestamp_ordered_multi_queue_merge_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam int unsigned LONG_HOLD    = 300;
  // Slowest run is roughly 1400 items plus holds; this is several times that.
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_func = tomq_pkg::FN_ENQ;
  logic [tomq_pkg::CLIENT_W-1:0] in_client_index = '0;
  logic [tomq_pkg::NOTE_W-1:0]   in_note_data = '0;
  logic [tomq_pkg::STAMP_W-1:0]  in_timestamp = '0;
  logic                          out_stall = 1'b0;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = tomq_pkg::CFG_ENABLE;
  logic [tomq_pkg::CFG_W-1:0]    cfg_wdata = '0;

  logic                          in_stall;
  logic                          out_valid;
  logic [1:0]                    out_status;
  logic [tomq_pkg::CLIENT_W-1:0] out_client;
  logic [tomq_pkg::NOTE_W-1:0]   out_note;
  logic [tomq_pkg::STAMP_W-1:0]  out_timestamp;

  int unsigned                   error_count;
  int unsigned                   outstanding;
  int unsigned                   cycle_count = 0;
  int unsigned                   results_taken = 0;
  logic [tomq_pkg::STAMP_W-1:0]  now_stamp = 64'd100;
  bit                            sender_quiet = 1'b0;

  timestamp_ordered_multi_queue_merge uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_client_index (in_client_index),
    .in_note_data    (in_note_data),
    .in_timestamp    (in_timestamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_client      (out_client),
    .out_note        (out_note),
    .out_timestamp   (out_timestamp),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  tomq_merge_checker merge_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_client_index (in_client_index),
    .in_note_data    (in_note_data),
    .in_timestamp    (in_timestamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_client      (out_client),
    .out_note        (out_note),
    .out_timestamp   (out_timestamp),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .error_count     (error_count),
    .outstanding     (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one transaction after a random gap and returns at the edge that accepts it.
  task automatic offer_txn(logic fn, logic [tomq_pkg::CLIENT_W-1:0] client,
                           logic [tomq_pkg::NOTE_W-1:0] note,
                           logic [tomq_pkg::STAMP_W-1:0] stamp);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_client_index <= client;
    in_note_data <= note;
    in_timestamp <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic push_note(logic [tomq_pkg::CLIENT_W-1:0] client,
                           logic [tomq_pkg::NOTE_W-1:0] note,
                           logic [tomq_pkg::STAMP_W-1:0] stamp);
    offer_txn(tomq_pkg::FN_ENQ, client, note, stamp);
  endtask

  // Fields other than the function are don't-care on a dequeue, so they carry noise.
  task automatic pop_oldest();
    offer_txn(tomq_pkg::FN_DEQ, tomq_pkg::CLIENT_W'($urandom_range(0, 7)), $urandom,
              {$urandom, $urandom});
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [tomq_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: a random hold-off before each result, quiet stretches, and two long
  // hold-offs that let the block back up into its input.
  initial begin
    int unsigned hold;
    @(posedge clk iff rst_n);
    forever begin
      if (results_taken == 400 || results_taken == 1000) begin
        hold = LONG_HOLD;
      end else if ((results_taken / 120) % 4 == 3) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 15);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  initial begin
    logic [tomq_pkg::ENABLE_W-1:0] en;
    logic [tomq_pkg::CFG_W-1:0]    lim;
    int unsigned                   enq_pct;
    int unsigned                   pick;
    logic [tomq_pkg::CLIENT_W-1:0] client;
    logic [tomq_pkg::STAMP_W-1:0]  stamp;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset every client is disabled.
    push_note(0, 32'h1234_5678, 64'd1);
    pop_oldest();

    write_reg(tomq_pkg::CFG_ENABLE, 8'hFF);
    write_reg(tomq_pkg::CFG_LIMIT, 8'd2);
    push_note(0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_note(7, 32'h0000_0000, 64'd0);
    push_note(3, 32'hA5A5_A5A5, 64'd5);
    push_note(3, 32'h5A5A_5A5A, 64'd5);
    push_note(3, 32'h0F0F_0F0F, 64'd6);
    push_note(5, 32'hC3C3_C3C3, 64'd5);
    // Drains 7, then the tie at 5 (client 5 first), client 3 twice, client 0, then empty.
    repeat (6) pop_oldest();

    // Notes of a disabled client stay queued but are invisible to a dequeue.
    push_note(1, 32'h1111_1111, 64'd10);
    push_note(2, 32'h2222_2222, 64'd9);
    write_reg(tomq_pkg::CFG_ENABLE, 8'hF9);
    push_note(1, 32'h3333_3333, 64'd11);
    pop_oldest();
    write_reg(tomq_pkg::CFG_ENABLE, 8'hFF);

    // Lowering the limit below the fill keeps the notes and rejects new ones.
    push_note(4, 32'h4444_4444, 64'd11);
    push_note(4, 32'h5555_5555, 64'd12);
    write_reg(tomq_pkg::CFG_LIMIT, 8'd1);
    push_note(4, 32'h6666_6666, 64'd13);
    write_reg(tomq_pkg::CFG_LIMIT, 8'd0);
    push_note(6, 32'h7777_7777, 64'd14);
    repeat (5) pop_oldest();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        // Limit above the depth, with junk in the upper write bits.
        en = 8'hFF;
        lim = {3'($urandom_range(0, 7)), 5'd31};
        enq_pct = 70;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          en = 8'hFF;
        end else if (pick < 9) begin
          en = tomq_pkg::ENABLE_W'($urandom_range(0, 255));
        end else begin
          en = $urandom_range(0, 1) ? 8'h00 : (8'h01 << $urandom_range(0, 7));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          lim = 0;
        end else if (pick == 1) begin
          lim = 1;
        end else if (pick == 2) begin
          lim = 31;
        end else if (pick < 6) begin
          lim = tomq_pkg::CFG_W'($urandom_range(1, 4));
        end else begin
          lim = tomq_pkg::CFG_W'($urandom_range(1, 31));
        end
        lim[7:5] = 3'($urandom_range(0, 7));
        enq_pct = $urandom_range(35, 70);
      end
      write_reg(tomq_pkg::CFG_ENABLE, en);
      write_reg(tomq_pkg::CFG_LIMIT, lim);
      sender_quiet = (ph % 4 == 2);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < enq_pct) begin
          if (en != 0 && $urandom_range(0, 9) != 0) begin
            do client = tomq_pkg::CLIENT_W'($urandom_range(0, 7)); while (!en[client]);
          end else begin
            client = tomq_pkg::CLIENT_W'($urandom_range(0, 7));
          end
          // Mostly rising stamps with frequent ties; now and then an arbitrary one.
          if ($urandom_range(0, 19) == 0) begin
            stamp = {$urandom, $urandom};
          end else begin
            now_stamp = now_stamp + 64'($urandom_range(0, 3));
            stamp = now_stamp;
          end
          push_note(client, $urandom, stamp);
        end else begin
          pop_oldest();
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
